/* sv/uplink_frame_pacer_with_catchup_defines.svh */
// Assertion macros shared by the frame pacer checker.
// Depends on nothing; the including file supplies clock and reset names.
`ifndef UPLINK_FRAME_PACER_WITH_CATCHUP_DEFINES_SVH
`define UPLINK_FRAME_PACER_WITH_CATCHUP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UPF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pacer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define UPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pacer check failed");

`endif

/* sv/upf_pkg.sv */
// Types and constants of the uplink frame pacer.
// Used by the pacer core, the top level and the checker; depends on nothing.
package upf_pkg;

    // Fixed field widths.
    localparam int unsigned GEN_W   = 32;
    localparam int unsigned BL_W    = 11;
    localparam int unsigned TIME_W  = 48;
    localparam int unsigned CNT_W   = 8;
    localparam int unsigned OP_W    = 3;
    localparam int unsigned STS_W   = 2;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned CIDX_W  = 2;
    localparam int unsigned IN_DW   = 96;
    localparam int unsigned OUT_DW  = 88;

    // Largest backlog the ring reports; larger values saturate.
    localparam logic [BL_W-1:0] BACKLOG_MAX = 11'd1024;

    // Event codes.
    localparam logic [OP_W-1:0] OP_SET_GEN   = 3'd0;
    localparam logic [OP_W-1:0] OP_RUN_BEGIN = 3'd1;
    localparam logic [OP_W-1:0] OP_FRAME_CHK = 3'd2;
    localparam logic [OP_W-1:0] OP_FRAME_OUT = 3'd3;
    localparam logic [OP_W-1:0] OP_RUN_END   = 3'd4;

    // Status codes.
    localparam logic [STS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STS_W-1:0] STS_CLOSED    = 2'd1;
    localparam logic [STS_W-1:0] STS_SEND_FAIL = 2'd2;
    localparam logic [STS_W-1:0] STS_RING_ERR  = 2'd3;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_BASE_QUOTA  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_SURGE_QUOTA = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_CATCHUP_THR = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_RUN_WINDOW  = 2'd3;

    // Input request payload, last field in the lowest bits.
    typedef struct packed {
        logic              pad;
        logic              consume_ok;
        logic              send_ok;
        logic              frame_ready;
        logic [TIME_W-1:0] now_time;
        logic [BL_W-1:0]   backlog;
        logic              ring_accepting;
        logic [GEN_W-1:0]  generation_in;
    } t_in_data;

    // Result payload, last field in the lowest bits.
    typedef struct packed {
        logic [4:0]        pad;
        logic [TIME_W-1:0] drain_time;
        logic [BL_W-1:0]   peak_backlog;
        logic              catchup_done;
        logic              catchup_began;
        logic [BL_W-1:0]   remaining;
        logic [CNT_W-1:0]  sent_count;
        logic              go_send;
        logic [STS_W-1:0]  status;
    } t_out_data;

    // Configuration registers.
    typedef struct packed {
        logic [CNT_W-1:0] base_quota;
        logic [CNT_W-1:0] surge_quota;
        logic [BL_W-1:0]  catchup_threshold;
        logic [CFG_W-1:0] run_window_us;
    } t_cfg;

    // Pacer state carried from one event to the next.
    typedef struct packed {
        logic [GEN_W-1:0]  session_gen;
        logic              catching_up;
        logic [TIME_W-1:0] catchup_start_time;
        logic [BL_W-1:0]   catchup_peak;
        logic              run_open;
        logic [TIME_W-1:0] run_start_time;
        logic [CNT_W-1:0]  frames_done;
        logic [CNT_W-1:0]  batch_limit;
        logic [STS_W-1:0]  run_status;
    } t_state;

endpackage

/* sv/upf_core.sv */
// Event logic of the frame pacer: next state and result for one request.
// Depends on upf_pkg; purely combinational.
module upf_core (
    input  logic [upf_pkg::OP_W-1:0] i_operation,
    input  upf_pkg::t_in_data        i_data,
    input  upf_pkg::t_cfg            i_cfg,
    input  upf_pkg::t_state          i_state,
    output upf_pkg::t_state          o_state,
    output upf_pkg::t_out_data       o_result
);

    logic [upf_pkg::BL_W-1:0]   w_bl;
    logic                       w_start;
    logic                       w_catch_eff;
    logic [upf_pkg::BL_W-1:0]   w_peak_eff;
    logic [upf_pkg::TIME_W-1:0] w_start_eff;
    logic [upf_pkg::TIME_W-1:0] w_run_age;
    logic                       w_budget_spent;
    logic                       w_frame_open;

    // Saturate the reported backlog.
    assign w_bl = (i_data.backlog > upf_pkg::BACKLOG_MAX) ? upf_pkg::BACKLOG_MAX
                                                          : i_data.backlog;

    // Catch-up start and peak tracking, shared by run begin and run end.
    assign w_start     = !i_state.catching_up && (w_bl >= i_cfg.catchup_threshold);
    assign w_catch_eff = i_state.catching_up || w_start;
    assign w_start_eff = w_start ? i_data.now_time : i_state.catchup_start_time;

    always_comb begin
        if (w_start) begin
            w_peak_eff = w_bl;
        end else if (i_state.catching_up && (w_bl > i_state.catchup_peak)) begin
            w_peak_eff = w_bl;
        end else begin
            w_peak_eff = i_state.catchup_peak;
        end
    end

    // Time spent in the current run, modulo the timestamp width.
    assign w_run_age      = i_data.now_time - i_state.run_start_time;
    assign w_budget_spent = (i_state.frames_done != '0) &&
                            (w_run_age >= {{(upf_pkg::TIME_W-upf_pkg::CFG_W){1'b0}},
                                           i_cfg.run_window_us});
    assign w_frame_open   = i_state.run_open &&
                            (i_state.frames_done < i_state.batch_limit);

    always_comb begin
        o_state  = i_state;
        o_result = '0;

        unique case (i_operation)
            // New generation: abandon the run and drop catch-up.
            upf_pkg::OP_SET_GEN: begin
                o_state.session_gen        = i_data.generation_in;
                o_state.catching_up        = 1'b0;
                o_state.catchup_start_time = '0;
                o_state.catchup_peak       = '0;
                o_state.run_open           = 1'b0;
            end

            // Open a run with a normal or catch-up batch, unless the generation is zero or the ring refuses.
            upf_pkg::OP_RUN_BEGIN: begin
                if (i_state.session_gen == '0) begin
                    o_state.run_open = 1'b0;
                    o_result.status  = upf_pkg::STS_RING_ERR;
                end else if (!i_data.ring_accepting) begin
                    o_state.run_open   = 1'b0;
                    o_result.status    = upf_pkg::STS_CLOSED;
                    o_result.remaining = w_bl;
                end else begin
                    o_state.run_start_time     = i_data.now_time;
                    o_state.catching_up        = w_catch_eff;
                    o_state.catchup_start_time = w_start_eff;
                    o_state.catchup_peak       = w_peak_eff;
                    o_state.batch_limit        = w_catch_eff ? i_cfg.surge_quota
                                                             : i_cfg.base_quota;
                    o_state.frames_done        = '0;
                    o_state.run_status         = upf_pkg::STS_OK;
                    o_state.run_open           = 1'b1;
                    o_result.catchup_began     = w_start;
                end
            end

            // Grant or refuse the next send.
            upf_pkg::OP_FRAME_CHK: begin
                if (w_frame_open) begin
                    if (!i_data.ring_accepting) begin
                        o_state.run_status  = upf_pkg::STS_CLOSED;
                        o_state.batch_limit = i_state.frames_done;
                    end else if (w_budget_spent) begin
                        o_state.batch_limit = i_state.frames_done;
                    end else begin
                        o_result.go_send = 1'b1;
                    end
                end
                o_result.status     = i_state.run_open ? o_state.run_status : upf_pkg::STS_OK;
                o_result.sent_count = i_state.run_open ? o_state.frames_done : '0;
            end

            // Account for the peek, send and consume of one frame.
            upf_pkg::OP_FRAME_OUT: begin
                if (w_frame_open) begin
                    if (!i_data.frame_ready) begin
                        o_state.batch_limit = i_state.frames_done;
                    end else if (!i_data.send_ok) begin
                        o_state.run_status  = upf_pkg::STS_SEND_FAIL;
                        o_state.batch_limit = i_state.frames_done;
                    end else if (!i_data.consume_ok) begin
                        o_state.run_status  = upf_pkg::STS_RING_ERR;
                        o_state.batch_limit = i_state.frames_done;
                    end else begin
                        o_state.frames_done = i_state.frames_done + 1'b1;
                        if (i_state.catching_up && (w_bl > i_state.catchup_peak)) begin
                            o_state.catchup_peak = w_bl;
                        end
                    end
                end
                o_result.status     = i_state.run_open ? o_state.run_status : upf_pkg::STS_OK;
                o_result.sent_count = i_state.run_open ? o_state.frames_done : '0;
            end

            // Close the run; catch-up may start or finish here.
            upf_pkg::OP_RUN_END: begin
                o_result.remaining = w_bl;
                if (!i_state.run_open) begin
                    o_result.status = upf_pkg::STS_RING_ERR;
                end else begin
                    o_state.run_open    = 1'b0;
                    o_result.status     = i_state.run_status;
                    o_result.sent_count = i_state.frames_done;
                    if (i_state.run_status == upf_pkg::STS_OK) begin
                        o_result.catchup_began = w_start;
                        if (w_catch_eff && (w_bl < i_cfg.catchup_threshold)) begin
                            o_result.catchup_done      = 1'b1;
                            o_result.peak_backlog      = w_peak_eff;
                            o_result.drain_time        = i_data.now_time - w_start_eff;
                            o_state.catching_up        = 1'b0;
                            o_state.catchup_start_time = '0;
                            o_state.catchup_peak       = '0;
                        end else begin
                            o_state.catching_up        = w_catch_eff;
                            o_state.catchup_start_time = w_start_eff;
                            o_state.catchup_peak       = w_peak_eff;
                        end
                    end
                end
            end

            // Unused codes leave everything as it is.
            default: begin
                o_result.status = upf_pkg::STS_OK;
            end
        endcase
    end

endmodule

/* sv/uplink_frame_pacer_with_catchup.sv */
// A result is registered and valid in the cycle after its request is accepted.
// One request per cycle is taken while the result stream is not stalled; the event
// logic is a single pass from the request into the state and result registers.
// Reset (synchronous, active low) clears the pacer state and the result valid,
// and loads the configuration registers with their default values.
module uplink_frame_pacer_with_catchup (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port.
    input  logic                          i_cfg_we,
    input  logic [upf_pkg::CIDX_W-1:0]    i_cfg_index,
    input  logic [upf_pkg::CFG_W-1:0]     i_cfg_data,
    // Request stream.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // generation_in[31:0], ring_accepting[32], backlog[43:33], now_time[91:44],
    // frame_ready[92], send_ok[93], consume_ok[94], zero[95]
    input  logic [upf_pkg::IN_DW-1:0]     s_axis_tdata,
    // operation[2:0]
    input  logic [upf_pkg::OP_W-1:0]      s_axis_tuser,
    // Result stream.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // status[1:0], go_send[2], sent_count[10:3], remaining[21:11],
    // catchup_began[22], catchup_done[23], peak_backlog[34:24],
    // drain_time[82:35], zero[87:83]
    output logic [upf_pkg::OUT_DW-1:0]    m_axis_tdata
);

    upf_pkg::t_cfg      r_cfg;
    upf_pkg::t_state    r_state;
    upf_pkg::t_state    n_state;
    upf_pkg::t_out_data n_result;
    upf_pkg::t_out_data r_result;
    logic               r_m_valid;
    logic               w_accept;

    // A new request is taken whenever the result register is free or draining.
    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_quota        <= 8'd1;
            r_cfg.surge_quota       <= 8'd4;
            r_cfg.catchup_threshold <= 11'd8;
            r_cfg.run_window_us     <= 32'd20000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                upf_pkg::CFG_BASE_QUOTA:  r_cfg.base_quota <=
                                              i_cfg_data[upf_pkg::CNT_W-1:0];
                upf_pkg::CFG_SURGE_QUOTA: r_cfg.surge_quota <=
                                              i_cfg_data[upf_pkg::CNT_W-1:0];
                upf_pkg::CFG_CATCHUP_THR: r_cfg.catchup_threshold <=
                                              i_cfg_data[upf_pkg::BL_W-1:0];
                upf_pkg::CFG_RUN_WINDOW:  r_cfg.run_window_us <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Event logic.
    upf_core u_core (
        .i_operation (s_axis_tuser),
        .i_data      (upf_pkg::t_in_data'(s_axis_tdata)),
        .i_cfg       (r_cfg),
        .i_state     (r_state),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    // Pacer state advances on every accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    // Result register with its valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_accept) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_result;

endmodule

/* sv/upf_checker.sv */
// Port-level checks of the frame pacer, bound to the top level.
// Depends on upf_pkg and the assertion macros header.
`include "uplink_frame_pacer_with_catchup_defines.svh"

module upf_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [upf_pkg::OUT_DW-1:0] m_axis_tdata
);

    upf_pkg::t_out_data w_res;

    assign w_res = upf_pkg::t_out_data'(m_axis_tdata);

    // A stalled result keeps its contents.
    `UPF_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // Every accepted request produces a result in the next cycle.
    `UPF_ASSERT_NEXT(a_result, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, m_axis_tvalid)

    // With the result register empty the request side is never stalled.
    `UPF_ASSERT_NOW(a_ready, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready)

    // A granted send or a finished catch-up only comes from a healthy run.
    `UPF_ASSERT_NOW(a_ok, i_clk, i_rst_n, m_axis_tvalid && (w_res.go_send || w_res.catchup_done), w_res.status == upf_pkg::STS_OK && !(w_res.catchup_done && w_res.catchup_began))

endmodule

bind uplink_frame_pacer_with_catchup upf_checker u_upf_checker (.*);
